// ===== hw/rtl/wts_pkg.sv =====
`timescale 1ns / 1ps
package wts_pkg;

    localparam int unsigned NUM_CFG   = 7;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned CLIP_W    = 49;
    localparam int unsigned MAG_W     = 49;
    localparam int unsigned DEN_W     = 48;
    localparam int unsigned SIZE_W    = 16;
    localparam int unsigned PROD_W    = MAG_W + SIZE_W;
    localparam int unsigned QUO_W     = 32;
    localparam int unsigned SCALE_SH  = 17;
    localparam int unsigned LOW_W     = 32;
    localparam logic signed [CLIP_W-1:0] W_MIN = 49'sd66;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_X_FIRST  = 3'd0,
        REG_ROW_X_SECOND = 3'd1,
        REG_ROW_Y_FIRST  = 3'd2,
        REG_ROW_Y_SECOND = 3'd3,
        REG_ROW_W_FIRST  = 3'd4,
        REG_ROW_W_SECOND = 3'd5,
        REG_SCREEN_SIZE  = 3'd6,
        REG_NONE         = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic vld;
        logic ok;
    } t_tag;

endpackage

// ===== hw/rtl/wts_clip.sv =====
`timescale 1ns / 1ps
module wts_clip
    import wts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [31:0]       i_pos_x,
    input  logic signed [31:0]       i_pos_y,
    input  logic signed [31:0]       i_pos_z,
    input  logic [5:0][CFG_W-1:0]    i_mat,
    input  logic [31:0]              i_screen,
    output t_tag                     o_tag,
    output logic                     o_neg_x,
    output logic [MAG_W-1:0]         o_mag_x,
    output logic                     o_neg_y,
    output logic [MAG_W-1:0]         o_mag_y,
    output logic [DEN_W-1:0]         o_den
);

    logic signed [31:0] w_ent [0:2][0:3];
    logic signed [31:0] w_pos [0:2];
    logic signed [63:0] n_prod [0:2][0:2];
    logic signed [63:0] r_prod [0:2][0:2];
    logic               r_s1_vld;
    logic signed [CLIP_W-1:0] n_clip [0:2];
    logic signed [CLIP_W-1:0] r_clip [0:2];
    logic               r_s2_vld;
    logic signed [CLIP_W:0] w_nx, w_ny;
    logic               w_ok;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 4; k++) begin
                w_ent[r][k] = i_mat[2*r + k/2][32*(k%2) +: 32];
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[r][k] = w_ent[r][k] * w_pos[k];
            end
        end
    end

    // floored products plus the offset entry
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_clip[r] = CLIP_W'($signed(r_prod[r][0][63:16]))
                      + CLIP_W'($signed(r_prod[r][1][63:16]))
                      + CLIP_W'($signed(r_prod[r][2][63:16]))
                      + CLIP_W'(w_ent[r][3]);
        end
    end

    assign w_nx = (CLIP_W+1)'(r_clip[2]) + (CLIP_W+1)'(r_clip[0]);
    assign w_ny = (CLIP_W+1)'(r_clip[2]) - (CLIP_W+1)'(r_clip[1]);
    assign w_ok = (i_screen[15:0] != 16'd0) && (i_screen[31:16] != 16'd0)
               && (r_clip[2] >= W_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            o_tag     <= '0;
        end else begin
            r_s1_vld  <= i_vld;
            r_s2_vld  <= r_s1_vld;
            o_tag.vld <= r_s2_vld;
            o_tag.ok  <= w_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_clip  <= n_clip;
        o_neg_x <= w_nx[CLIP_W];
        o_mag_x <= w_nx[CLIP_W] ? MAG_W'(-w_nx) : MAG_W'(w_nx);
        o_neg_y <= w_ny[CLIP_W];
        o_mag_y <= w_ny[CLIP_W] ? MAG_W'(-w_ny) : MAG_W'(w_ny);
        o_den   <= r_clip[2][DEN_W-1:0];
    end

endmodule

// ===== hw/rtl/wts_div.sv =====
`timescale 1ns / 1ps
module wts_div
    import wts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tag                     i_tag,
    input  logic                     i_neg,
    input  logic [MAG_W-1:0]         i_mag,
    input  logic [SIZE_W-1:0]        i_size,
    input  logic [DEN_W-1:0]         i_den,
    output t_tag                     o_tag,
    output logic signed [31:0]       o_res
);

    t_tag               r_a_tag;
    logic               r_a_neg;
    logic [PROD_W-1:0]  r_a_prod;
    logic [DEN_W-1:0]   r_a_den;

    t_tag               r_tag [0:QUO_W];
    logic               r_neg [0:QUO_W];
    logic               r_ovf [0:QUO_W];
    logic [DEN_W-1:0]   r_den [0:QUO_W];
    logic [DEN_W-1:0]   r_rem [0:QUO_W];
    logic [LOW_W-1:0]   r_low [0:QUO_W];
    logic [QUO_W-1:0]   r_q   [0:QUO_W];

    logic [31:0]        n_res;
    logic [QUO_W-1:0]   w_q;

    // scale stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else begin
            r_a_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg  <= i_neg;
        r_a_prod <= PROD_W'(i_mag) * PROD_W'(i_size);
        r_a_den  <= i_den;
    end

    // saturation check and top of the dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= r_a_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg[0] <= r_a_neg;
        r_ovf[0] <= r_a_prod >= {r_a_den, {SCALE_SH{1'b0}}};
        r_den[0] <= r_a_den;
        r_rem[0] <= r_a_prod[PROD_W-1:SCALE_SH];
        r_low[0] <= {r_a_prod[SCALE_SH-1:0], {(LOW_W-SCALE_SH){1'b0}}};
        r_q[0]   <= '0;
    end

    // one quotient bit a stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_bit
        logic [DEN_W:0] w_t;
        logic [DEN_W:0] w_d;
        logic           w_ge;

        assign w_t  = {r_rem[k], r_low[k][LOW_W-1]};
        assign w_d  = {1'b0, r_den[k]};
        assign w_ge = w_t >= w_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1] <= '0;
            end else begin
                r_tag[k+1] <= r_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= w_ge ? DEN_W'(w_t - w_d) : w_t[DEN_W-1:0];
            r_low[k+1] <= {r_low[k][LOW_W-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][QUO_W-2:0], w_ge};
        end
    end

    assign w_q = r_q[QUO_W];

    always_comb begin
        if (!r_tag[QUO_W].ok) begin
            n_res = 32'd0;
        end else if (r_neg[QUO_W]) begin
            if (r_ovf[QUO_W] || (w_q > 32'h8000_0000)) begin
                n_res = 32'h8000_0000;
            end else begin
                n_res = -w_q;
            end
        end else begin
            if (r_ovf[QUO_W] || w_q[31]) begin
                n_res = 32'h7FFF_FFFF;
            end else begin
                n_res = w_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag <= '0;
        end else begin
            o_tag <= r_tag[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

endmodule

// ===== hw/rtl/perspective_world_to_screen.sv =====
`timescale 1ns / 1ps
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------
// point in  | i_start, o_busy      | i_pos_x, i_pos_y, i_pos_z
// result    | o_valid (strobe)     | o_screen_x, o_screen_y, o_valid_res
// config    | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// one point accepted every cycle; o_busy is never raised
// each result passes through the clip stages and then the
// 32-stage restoring divider (one quotient bit per stage)
// reset clears the config registers and every valid bit in the pipe
// the result side cannot stall, so nothing in the pipe ever waits
module perspective_world_to_screen
    import wts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [31:0]       i_pos_x,
    input  logic signed [31:0]       i_pos_y,
    input  logic signed [31:0]       i_pos_z,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_valid,
    output logic signed [31:0]       o_screen_x,
    output logic signed [31:0]       o_screen_y,
    output logic                     o_valid_res
);

    logic [5:0][CFG_W-1:0]  r_mat;
    logic [31:0]            r_screen;

    t_tag                   w_tag;
    logic                   w_neg_x, w_neg_y;
    logic [MAG_W-1:0]       w_mag_x, w_mag_y;
    logic [DEN_W-1:0]       w_den;
    t_tag                   w_tag_x, w_tag_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat    <= '0;
            r_screen <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ROW_X_FIRST, REG_ROW_X_SECOND, REG_ROW_Y_FIRST,
                REG_ROW_Y_SECOND, REG_ROW_W_FIRST, REG_ROW_W_SECOND: begin
                    r_mat[i_cfg_idx] <= i_cfg_data;
                end
                REG_SCREEN_SIZE: begin
                    r_screen <= i_cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy = 1'b0;

    wts_clip u_clip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_start),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_pos_z  (i_pos_z),
        .i_mat    (r_mat),
        .i_screen (r_screen),
        .o_tag    (w_tag),
        .o_neg_x  (w_neg_x),
        .o_mag_x  (w_mag_x),
        .o_neg_y  (w_neg_y),
        .o_mag_y  (w_mag_y),
        .o_den    (w_den)
    );

    wts_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_neg   (w_neg_x),
        .i_mag   (w_mag_x),
        .i_size  (r_screen[15:0]),
        .i_den   (w_den),
        .o_tag   (w_tag_x),
        .o_res   (o_screen_x)
    );

    wts_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_neg   (w_neg_y),
        .i_mag   (w_mag_y),
        .i_size  (r_screen[31:16]),
        .i_den   (w_den),
        .o_tag   (w_tag_y),
        .o_res   (o_screen_y)
    );

    assign o_valid     = w_tag_x.vld & w_tag_y.vld;
    assign o_valid_res = w_tag_x.ok & w_tag_y.ok;

endmodule

// ===== hw/rtl/wts_chk.sv =====
`timescale 1ns / 1ps
module wts_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               o_busy,
    input  logic               o_valid,
    input  logic signed [31:0] o_screen_x,
    input  logic signed [31:0] o_screen_y,
    input  logic               o_valid_res
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##38 o_valid)
        else $error("result missing after transaction");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_screen_x == 32'sd0 && o_screen_y == 32'sd0))
        else $error("rejected point with nonzero coordinates");

    a_neg_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res && o_screen_x[31]) |-> (o_screen_x != 32'sd0))
        else $error("bad sign on screen x");

endmodule

bind perspective_world_to_screen wts_chk u_wts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .o_screen_x  (o_screen_x),
    .o_screen_y  (o_screen_y),
    .o_valid_res (o_valid_res)
);

// ===== tb/wts_checker.sv =====
`timescale 1ns / 1ps
module wts_checker
    import wts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    input  logic signed [31:0] i_screen_x,
    input  logic signed [31:0] i_screen_y,
    input  logic               i_valid_res,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_points,
    output int                 o_projected
);

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic        ok;
    } t_pixel;

    logic [CFG_W-1:0] view_regs [NUM_CFG];
    t_pixel           pixel_q [$];

    function automatic longint matrix_entry(int base, int k);
        logic [63:0] r;
        r = view_regs[base + (k >> 1)];
        return (k & 1) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
    endfunction

    // products floored to q16.16 by arithmetic shift
    function automatic longint clip_coord(int base, longint px, longint py, longint pz);
        return ((matrix_entry(base, 0) * px) >>> 16) + ((matrix_entry(base, 1) * py) >>> 16)
             + ((matrix_entry(base, 2) * pz) >>> 16) + matrix_entry(base, 3);
    endfunction

    function automatic logic [31:0] pixel_scale(longint n, longint unsigned size, longint w);
        logic               neg;
        longint unsigned    mag, wd, q, rem, t, q2, r2, res;
        neg = n < 0;
        mag = neg ? longint'(-n) : n;
        wd  = w;
        q   = mag / wd;
        rem = mag % wd;
        if (q >= 64'd131072) begin
            res = 64'h1_0000_0000;
        end else begin
            t   = rem * size;
            q2  = t / wd;
            r2  = t % wd;
            res = q * size * 32768 + q2 * 32768 + (r2 << 15) / wd;
        end
        if (neg)
            return (res > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(res));
        return (res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(res);
    endfunction

    function automatic t_pixel project_point(longint px, longint py, longint pz);
        t_pixel          p;
        longint unsigned width, height;
        longint          cx, cy, cw;
        width  = view_regs[REG_SCREEN_SIZE][15:0];
        height = view_regs[REG_SCREEN_SIZE][31:16];
        cx = clip_coord(REG_ROW_X_FIRST, px, py, pz);
        cy = clip_coord(REG_ROW_Y_FIRST, px, py, pz);
        cw = clip_coord(REG_ROW_W_FIRST, px, py, pz);
        p  = '0;
        if (width != 0 && height != 0 && cw >= 66) begin
            p.sx = pixel_scale(cw + cx, width, cw);
            p.sy = pixel_scale(cw - cy, height, cw);
            p.ok = 1'b1;
        end
        return p;
    endfunction

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        t_pixel e;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++)
                view_regs[i] <= '0;
            pixel_q.delete();
            o_errors    <= 0;
            o_points    <= 0;
            o_projected <= 0;
        end else begin
            if (i_valid) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h ok=%b", $time,
                             i_screen_x, i_screen_y, i_valid_res);
                    o_errors <= o_errors + 1;
                end else begin
                    e = pixel_q.pop_front();
                    if (e.sx !== i_screen_x || e.sy !== i_screen_y || e.ok !== i_valid_res) begin
                        $display("%0t: expected x=%h y=%h ok=%b, got x=%h y=%h ok=%b", $time,
                                 e.sx, e.sy, e.ok, i_screen_x, i_screen_y, i_valid_res);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                e = project_point(i_pos_x, i_pos_y, i_pos_z);
                pixel_q.push_back(e);
                o_points <= o_points + 1;
                if (e.ok)
                    o_projected <= o_projected + 1;
            end
            if (i_cfg_we && i_cfg_idx < NUM_CFG)
                view_regs[i_cfg_idx] <= (i_cfg_idx == REG_SCREEN_SIZE) ?
                                        {32'd0, i_cfg_data[31:0]} : i_cfg_data;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import wts_pkg::*;

    localparam int LATENCY    = 38;
    localparam int IDLE_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = REG_ROW_X_FIRST;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               o_valid;
    logic signed [31:0] o_screen_x, o_screen_y;
    logic               o_valid_res;
    int                 errors, pending, points, projected;
    int                 idle_cycles = 0;
    int                 phases_run = 0;

    always #1 i_clk = ~i_clk;

    perspective_world_to_screen i_dut (.*);

    wts_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_screen_x(o_screen_x), .i_screen_y(o_screen_y),
        .i_valid_res(o_valid_res), .o_errors(errors), .o_pending(pending),
        .o_points(points), .o_projected(projected)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    logic [CFG_W-1:0] view_set [NUM_CFG];

    task automatic write_view_set();
        for (int i = 0; i < NUM_CFG; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(i);
            i_cfg_data <= view_set[i];
            @(posedge i_clk);
        end
        // out-of-range index must be ignored
        i_cfg_idx  <= REG_NONE;
        i_cfg_data <= {$urandom, $urandom};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phases_run++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending != 0 && guard < IDLE_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
        int r, gap;
        i_start <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        do @(posedge i_clk); while (o_busy);
        r   = $urandom_range(0, 99);
        gap = !gaps || r < 60 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40));
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] small_entry();
        return 32'($signed($urandom_range(0, 524288)) - 262144);
    endfunction

    function automatic logic [31:0] world_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
        if (r < 90)
            return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        return $urandom;
    endfunction

    task automatic random_view_set(bit wild);
        for (int i = 0; i < 6; i++)
            view_set[i] = wild ? {$urandom, $urandom} : {small_entry(), small_entry()};
        if (!wild)
            view_set[REG_ROW_W_SECOND][63:32] = $urandom_range(0, 20 << 16);
        view_set[REG_SCREEN_SIZE] = wild ? {32'd0, $urandom} :
            {32'd0, 16'($urandom_range(1, 2160)), 16'($urandom_range(1, 3840))};
    endtask

    task automatic random_points(int n);
        bit gaps;
        gaps = $urandom_range(0, 3) != 0;
        for (int k = 0; k < n; k++)
            send_point(world_coord(), world_coord(), world_coord(), gaps);
        i_start <= 1'b0;
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity view, w taken straight from z
        view_set[REG_ROW_X_FIRST]  = {32'd0, 32'h0001_0000};
        view_set[REG_ROW_X_SECOND] = '0;
        view_set[REG_ROW_Y_FIRST]  = {32'h0001_0000, 32'd0};
        view_set[REG_ROW_Y_SECOND] = '0;
        view_set[REG_ROW_W_FIRST]  = '0;
        view_set[REG_ROW_W_SECOND] = {32'd0, 32'h0001_0000};
        view_set[REG_SCREEN_SIZE]  = {32'd0, 16'd480, 16'd640};
        write_view_set();
        send_point(0, 0, 0, 0);
        send_point(0, 0, 65, 0);
        send_point(0, 0, 66, 0);
        send_point(0, 0, 32'h0001_0000, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 66, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 66, 0);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 0);
        send_point(0, 0, 32'h8000_0000, 0);
        send_point(0, 0, 32'h7FFF_FFFF, 0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0003_0000, 0);
        i_start <= 1'b0;
        drain();

        // empty screen in each direction
        view_set[REG_SCREEN_SIZE] = {32'd0, 16'd480, 16'd0};
        write_view_set();
        send_point(0, 0, 32'h0001_0000, 0);
        send_point(32'h0000_4000, 0, 32'h0002_0000, 0);
        i_start <= 1'b0;
        drain();
        view_set[REG_SCREEN_SIZE] = {32'd0, 16'd0, 16'd640};
        write_view_set();
        send_point(0, 0, 32'h0001_0000, 0);
        i_start <= 1'b0;
        drain();

        // largest screen, extreme entries
        for (int i = 0; i < 6; i++)
            view_set[i] = {32'h7FFF_FFFF, 32'h8000_0000};
        view_set[REG_ROW_W_SECOND] = {32'h7FFF_FFFF, 32'h0001_0000};
        view_set[REG_SCREEN_SIZE]  = {32'd0, 32'hFFFF_FFFF};
        write_view_set();
        send_point(0, 0, 0, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'h7FFF_FFFF, 0, 32'h0001_0000, 0);
        i_start <= 1'b0;
        drain();
        random_points(60);

        // all ones: every entry is minus one lsb
        for (int i = 0; i < 7; i++)
            view_set[i] = '1;
        write_view_set();
        random_points(40);

        for (int ph = 0; ph < 9; ph++) begin
            random_view_set(ph == 4 || ph == 8);
            write_view_set();
            random_points(70);
        end

        // back to reset-like values
        for (int i = 0; i < 7; i++)
            view_set[i] = '0;
        write_view_set();
        random_points(20);

        $display("points sent: %0d, projected: %0d, view settings: %0d",
                 points, projected, phases_run);
        $display("covered near-plane rejection, empty screens, saturation, random views");
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/wts_pkg.sv
hw/rtl/wts_clip.sv
hw/rtl/wts_div.sv
hw/rtl/perspective_world_to_screen.sv
hw/rtl/wts_chk.sv
tb/wts_checker.sv
tb/tb.sv
